FILE: src/swr_pkg.sv
package swr_pkg;

  localparam int unsigned InBytes   = 10;
  localparam int unsigned HalfBytes = 5;
  localparam int unsigned ByteIdxW  = $clog2(InBytes);

  typedef logic [InBytes-1:0][7:0] payload_t;
  typedef logic [InBytes-1:0]      keep_t;

  // "***End***" followed by a zero byte, byte 0 in the low lane
  localparam payload_t EndMark = {8'h00, 8'h2A, 8'h2A, 8'h2A, 8'h64,
                                  8'h6E, 8'h45, 8'h2A, 8'h2A, 8'h2A};

  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindAck  = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  // per-packet verdict from the checker
  typedef struct packed {
    logic        is_end;
    logic        pass;
    logic [15:0] sum;
    keep_t       keep;
  } check_t;

  // what the emitter needs to play out one packet
  typedef struct packed {
    logic        emit_bytes;
    kind_e       fin_kind;
    logic        ack_seq;
    logic [15:0] ack_check;
    logic        verdict;
  } load_t;

endpackage

FILE: src/swr_check.sv
module swr_check #(
  parameter int unsigned PAYLOAD_BYTES = 10
) (
  input  swr_pkg::payload_t payload_i,
  input  logic              seq_i,
  input  logic [15:0]       check_i,
  input  logic              expect_seq_i,
  output swr_pkg::check_t   result_o
);
  import swr_pkg::*;

  logic [18:0] acc;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] sum;
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic        alive;
  keep_t       keep;

  // little-endian words over the first PAYLOAD_BYTES bytes, odd byte alone
  always_comb begin
    acc = '0;
    for (int unsigned k = 0; k < InBytes / 2; k++) begin
      lo_b = (2 * k < PAYLOAD_BYTES) ? payload_i[2*k] : 8'h00;
      hi_b = (2 * k + 1 < PAYLOAD_BYTES) ? payload_i[2*k+1] : 8'h00;
      acc  = acc + {3'b000, hi_b, lo_b};
    end
  end

  // two end-around folds cover the worst-case carry
  assign fold1 = {1'b0, acc[15:0]} + {14'b0, acc[18:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};
  assign sum   = ~fold2;

  // keep: no zero byte so far within the current half
  always_comb begin
    alive = 1'b0;
    for (int unsigned i = 0; i < InBytes; i++) begin
      if (i % HalfBytes == 0) begin
        alive = (payload_i[i] != 8'h00);
      end else begin
        alive = alive & (payload_i[i] != 8'h00);
      end
      keep[i] = alive;
    end
  end

  assign result_o.is_end = (payload_i == EndMark);
  assign result_o.pass   = (sum == check_i) && (seq_i == expect_seq_i);
  assign result_o.sum    = sum;
  assign result_o.keep   = keep;

endmodule

FILE: src/swr_emit.sv
module swr_emit #(
  parameter int unsigned PAYLOAD_BYTES = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  swr_pkg::load_t    info_i,
  input  swr_pkg::payload_t payload_i,
  input  swr_pkg::keep_t    keep_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output swr_pkg::kind_e    result_kind_o,
  output logic [7:0]        out_byte_o,
  output logic              byte_keep_o,
  output logic              ack_seq_o,
  output logic [15:0]       ack_check_o,
  output logic              verdict_o,
  output logic              last_of_run_o
);
  import swr_pkg::*;

  localparam int unsigned IdxW = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [IdxW-1:0] FinIdx = IdxW'(PAYLOAD_BYTES);

  logic            active_q;
  logic [IdxW-1:0] idx_q;
  payload_t        bytes_q;
  keep_t           keep_q;
  load_t           info_q;

  logic                is_fin;
  logic                fire;
  logic [ByteIdxW-1:0] sel;

  assign is_fin = (idx_q == FinIdx);
  assign fire   = active_q & out_ready_i;
  assign free_o = ~active_q | (fire & is_fin);
  assign sel    = ByteIdxW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (load_i) begin
      active_q <= 1'b1;
      idx_q    <= info_i.emit_bytes ? '0 : FinIdx;
    end else if (fire) begin
      if (is_fin) begin
        active_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= payload_i;
      keep_q  <= keep_i;
      info_q  <= info_i;
    end
  end

  assign out_valid_o   = active_q;
  assign result_kind_o = is_fin ? info_q.fin_kind : KindByte;
  assign out_byte_o    = is_fin ? 8'h00 : bytes_q[sel];
  assign byte_keep_o   = is_fin ? 1'b0 : keep_q[sel];
  assign ack_seq_o     = is_fin ? info_q.ack_seq : 1'b0;
  assign ack_check_o   = is_fin ? info_q.ack_check : 16'h0000;
  assign verdict_o     = is_fin ? info_q.verdict : 1'b0;
  assign last_of_run_o = is_fin;

endmodule

FILE: src/stop_and_wait_receiver.sv
// Channel | Handshake                | Beat
// --------+--------------------------+---------------------------------------
// in      | in_valid_i / in_ready_o  | one packet: 10 bytes, seq, checksum
// out     | out_valid_o / out_ready_i| one result: byte, ack or end marker
//
// A packet sits in the input register and is judged and handed to the emitter
// once the emitter is free. An accepted packet plays out PAYLOAD_BYTES byte
// beats plus one ack beat; a rejected or end packet takes one beat, an ignored
// one (after end) none. The next packet is loaded in the cycle the final beat
// is taken. Reset clears ack state, end flag, valids. A stall on out_ready_i
// holds the current beat and backs up into in_ready_o.
module stop_and_wait_receiver #(
  parameter int unsigned PAYLOAD_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  payload_byte_0_i,
  input  logic [7:0]  payload_byte_1_i,
  input  logic [7:0]  payload_byte_2_i,
  input  logic [7:0]  payload_byte_3_i,
  input  logic [7:0]  payload_byte_4_i,
  input  logic [7:0]  payload_byte_5_i,
  input  logic [7:0]  payload_byte_6_i,
  input  logic [7:0]  payload_byte_7_i,
  input  logic [7:0]  payload_byte_8_i,
  input  logic [7:0]  payload_byte_9_i,
  input  logic        packet_seq_i,
  input  logic [15:0] packet_check_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_keep_o,
  output logic        ack_seq_o,
  output logic [15:0] ack_check_o,
  output logic        verdict_o,
  output logic        last_of_run_o
);
  import swr_pkg::*;

  // input register
  logic        in_valid_q;
  payload_t    pay_q;
  logic        seq_q;
  logic [15:0] check_q;

  // protocol state
  logic        ack_seq_q;
  logic [15:0] ack_check_q;
  logic        done_q;

  logic   in_fire;
  logic   free;
  logic   load;
  logic   emit_load;
  check_t chk;
  load_t  info;
  kind_e  kind;

  assign in_fire    = in_valid_i & in_ready_o;
  assign load       = in_valid_q & free;
  assign in_ready_o = ~in_valid_q | load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pay_q   <= {payload_byte_9_i, payload_byte_8_i, payload_byte_7_i,
                  payload_byte_6_i, payload_byte_5_i, payload_byte_4_i,
                  payload_byte_3_i, payload_byte_2_i, payload_byte_1_i,
                  payload_byte_0_i};
      seq_q   <= packet_seq_i;
      check_q <= packet_check_i;
    end
  end

  swr_check #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_check (
    .payload_i   (pay_q),
    .seq_i       (seq_q),
    .check_i     (check_q),
    .expect_seq_i(~ack_seq_q),
    .result_o    (chk)
  );

  // state moves when the packet is handed over, so the next one sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_seq_q   <= 1'b0;
      ack_check_q <= 16'h0000;
      done_q      <= 1'b0;
    end else if (load && !done_q) begin
      if (chk.is_end) begin
        done_q <= 1'b1;
      end else if (chk.pass) begin
        ack_seq_q   <= ~ack_seq_q;
        ack_check_q <= chk.sum;
      end
    end
  end

  always_comb begin
    if (chk.is_end) begin
      info.emit_bytes = 1'b0;
      info.fin_kind   = KindEnd;
      info.ack_seq    = 1'b0;
      info.ack_check  = 16'h0000;
      info.verdict    = 1'b0;
    end else if (chk.pass) begin
      info.emit_bytes = 1'b1;
      info.fin_kind   = KindAck;
      info.ack_seq    = ~ack_seq_q;
      info.ack_check  = chk.sum;
      info.verdict    = 1'b0;
    end else begin
      // resend the stored ack
      info.emit_bytes = 1'b0;
      info.fin_kind   = KindAck;
      info.ack_seq    = ack_seq_q;
      info.ack_check  = ack_check_q;
      info.verdict    = 1'b1;
    end
  end

  // after the end marker packets are drained without results
  assign emit_load = load & ~done_q;

  swr_emit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_load),
    .info_i       (info),
    .payload_i    (pay_q),
    .keep_i       (chk.keep),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(kind),
    .out_byte_o   (out_byte_o),
    .byte_keep_o  (byte_keep_o),
    .ack_seq_o    (ack_seq_o),
    .ack_check_o  (ack_check_o),
    .verdict_o    (verdict_o),
    .last_of_run_o(last_of_run_o)
  );

  assign result_kind_o = kind;

endmodule

FILE: bench/tb_stop_and_wait_receiver.sv
module tb_stop_and_wait_receiver;
  import swr_pkg::*;

  localparam int unsigned PayloadBytes  = 10;
  localparam int unsigned RandomPackets = 410;
  // Cycles with no beat on either channel before the run is abandoned.
  localparam int unsigned WatchdogLimit = 1000;
  // Quiet time waited after the last expected beat.
  localparam int unsigned SettleCycles  = 2 * (PayloadBytes + 1) + 8;

  // One packet as offered on the input channel. drain holds the packet back
  // until every beat owed so far has come out.
  typedef struct {
    payload_t    data;
    logic        seq;
    logic [15:0] check;
    bit          drain;
  } pkt_t;

  // One output beat as the block should emit it.
  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic        keep;
    logic        ack_seq;
    logic [15:0] ack_sum;
    logic        verdict;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  payload_t    pkt_bytes = '0;
  logic        pkt_seq = 1'b0;
  logic [15:0] pkt_check = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  out_byte_o;
  logic        byte_keep_o;
  logic        ack_seq_o;
  logic [15:0] ack_check_o;
  logic        verdict_o;
  logic        last_of_run_o;

  // Packets waiting to be offered, and beats the receiver still owes.
  pkt_t    pkt_q[$];
  result_t expected_q[$];

  // Receiver state as predicted: last acked bit and sum, end-of-transfer flag.
  logic        rx_ack_bit = 1'b0;
  logic [15:0] rx_ack_sum = '0;
  logic        rx_finished = 1'b0;

  // Ack bit the packet generator believes the receiver holds.
  logic gen_ack = 1'b0;

  int unsigned beats_due = 0;   // beats predicted, driver side
  int unsigned beats_seen = 0;  // beats taken, monitor side (nonblocking)
  int unsigned n_sent = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_hold = 0;
  int unsigned out_stall = 0;
  pkt_t        cur_pkt;

  always #1 clk_i = ~clk_i;

  stop_and_wait_receiver #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .payload_byte_0_i(pkt_bytes[0]),
    .payload_byte_1_i(pkt_bytes[1]),
    .payload_byte_2_i(pkt_bytes[2]),
    .payload_byte_3_i(pkt_bytes[3]),
    .payload_byte_4_i(pkt_bytes[4]),
    .payload_byte_5_i(pkt_bytes[5]),
    .payload_byte_6_i(pkt_bytes[6]),
    .payload_byte_7_i(pkt_bytes[7]),
    .payload_byte_8_i(pkt_bytes[8]),
    .payload_byte_9_i(pkt_bytes[9]),
    .packet_seq_i    (pkt_seq),
    .packet_check_i  (pkt_check),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .out_byte_o      (out_byte_o),
    .byte_keep_o     (byte_keep_o),
    .ack_seq_o       (ack_seq_o),
    .ack_check_o     (ack_check_o),
    .verdict_o       (verdict_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Internet checksum: little-endian words (even byte low), end-around carry,
  // odd trailing byte added alone, then inverted.
  function automatic logic [15:0] inet_checksum(input payload_t b);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i + 1 < PayloadBytes; i += 2) acc += {16'h0, b[i+1], b[i]};
    if (PayloadBytes % 2 != 0) acc += {24'h0, b[PayloadBytes-1]};
    while (acc[31:16] != 0) acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // A packet is taken when its sum matches and it carries the new bit.
  function automatic bit packet_passes(input pkt_t p, input logic ack_bit);
    return inet_checksum(p.data) == p.check && p.seq == ~ack_bit;
  endfunction

  function automatic result_t make_result(input kind_e k, input logic [7:0] d,
                                          input logic keep, input logic aseq,
                                          input logic [15:0] asum,
                                          input logic verdict, input logic last);
    result_t r;
    r.kind    = k;
    r.data    = d;
    r.keep    = keep;
    r.ack_seq = aseq;
    r.ack_sum = asum;
    r.verdict = verdict;
    r.last    = last;
    return r;
  endfunction

  // Works out the beats one accepted packet causes and queues them.
  function automatic void predict_results(input pkt_t p);
    logic alive;
    alive = 1'b1;
    if (rx_finished) return;  // after the end marker nothing comes out
    if (p.data == EndMark) begin
      // end marker: no sum or bit check, a single end beat
      rx_finished = 1'b1;
      expected_q.push_back(make_result(KindEnd, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1));
      beats_due++;
    end else if (packet_passes(p, rx_ack_bit)) begin
      rx_ack_bit = ~rx_ack_bit;
      rx_ack_sum = p.check;
      for (int i = 0; i < PayloadBytes; i++) begin
        // keep restarts at each five-byte half and drops at the first zero
        if (i % HalfBytes == 0) alive = 1'b1;
        if (p.data[i] == 8'h00) alive = 1'b0;
        expected_q.push_back(make_result(KindByte, p.data[i], alive, 1'b0, '0,
                                         1'b0, 1'b0));
      end
      expected_q.push_back(make_result(KindAck, '0, 1'b0, rx_ack_bit, rx_ack_sum,
                                       1'b0, 1'b1));
      beats_due += PayloadBytes + 1;
    end else begin
      // wrong sum, stale bit or duplicate: repeat the stored ack
      expected_q.push_back(make_result(KindAck, '0, 1'b0, rx_ack_bit, rx_ack_sum,
                                       1'b1, 1'b1));
      beats_due++;
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Queues a packet and tracks the ack bit the generator expects next.
  function automatic void add_packet(input payload_t b, input logic seq,
                                     input logic [15:0] chk, input bit drain);
    pkt_t p;
    p.data  = b;
    p.seq   = seq;
    p.check = chk;
    p.drain = drain;
    if (b != EndMark && packet_passes(p, gen_ack)) gen_ack = ~gen_ack;
    pkt_q.push_back(p);
  endfunction

  // Well-formed packet: right sum, next bit.
  function automatic void add_good(input payload_t b, input bit drain);
    add_packet(b, ~gen_ack, inet_checksum(b), drain);
  endfunction

  // Bytes skewed toward zero and 0xFF so the keep flags and folding get work.
  function automatic payload_t random_payload();
    payload_t b;
    for (int i = 0; i < InBytes; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    b[i] = 8'h00;
        2:       b[i] = 8'hFF;
        default: b[i] = 8'($urandom);
      endcase
    end
    return b;
  endfunction

  // Driver: offers the next packet once the previous beat is taken and the
  // drawn gap has run out. Prediction happens at the accepting edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_hold = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_results(cur_pkt);
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_hold != 0) begin
          send_hold--;
          in_valid_i <= 1'b0;
        end else if (pkt_q.size() != 0 &&
                     !(pkt_q[0].drain && beats_due != beats_seen)) begin
          cur_pkt = pkt_q.pop_front();
          in_valid_i <= 1'b1;
          pkt_bytes  <= cur_pkt.data;
          pkt_seq    <= cur_pkt.seq;
          pkt_check  <= cur_pkt.check;
          // every fifth stretch of 40 packets is sent back to back
          send_hold = ((n_sent / 40) % 5 == 3) ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each beat against the oldest prediction, then draws
  // how long to hold ready low before the next beat.
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat, kind %0d", result_kind_o);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          compare_field("result_kind", want.kind, result_kind_o);
          compare_field("out_byte", want.data, out_byte_o);
          compare_field("byte_keep", want.keep, byte_keep_o);
          compare_field("ack_seq", want.ack_seq, ack_seq_o);
          compare_field("ack_check", want.ack_sum, ack_check_o);
          compare_field("verdict", want.verdict, verdict_o);
          compare_field("last_of_run", want.last, last_of_run_o);
        end
        beats_seen <= beats_seen + 1;
        out_stall = ((beats_seen / 60) % 5 == 4) ? 0 : $urandom_range(0, 4);
      end else if (out_stall != 0) begin
        out_stall--;
      end
      out_ready_i <= (out_stall == 0);
    end
  end

  // Watchdog: any beat on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $error("no beat for %0d cycles, %0d beats still owed", idle_cycles,
             expected_q.size());
      $display("tb_stop_and_wait_receiver: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    payload_t b;
    int unsigned pick;

    // --- directed ---
    // nothing acked yet: stale bit gets the reset ack back
    add_packet('0, 1'b0, 16'hFFFF, 1'b0);
    b = random_payload();
    add_packet(b, 1'b1, ~inet_checksum(b), 1'b0);      // bad sum
    add_good('0, 1'b0);                                // all zero, sum 0xFFFF
    add_good({InBytes{8'hFF}}, 1'b0);                  // full carry fold, sum 0
    add_packet({InBytes{8'hFF}}, 1'b0, 16'h0000, 1'b0); // duplicate
    // zeros at bytes 2 and 5: keep drops at byte 2, restarts on a zero at byte 5 and stays low
    add_good({8'h0A, 8'h09, 8'h08, 8'h07, 8'h00,
              8'h05, 8'h04, 8'h00, 8'h02, 8'h01}, 1'b0);
    add_good({8'h89, 8'h88, 8'h87, 8'h86, 8'h85,
              8'h84, 8'h83, 8'h82, 8'h81, 8'h80}, 1'b0);
    add_good({InBytes{8'h55}}, 1'b0);
    add_good({InBytes{8'hAA}}, 1'b0);
    // near misses of the end marker are ordinary packets
    b = EndMark;
    b[9] = 8'h01;
    add_good(b, 1'b0);
    add_packet(b, gen_ack, inet_checksum(b), 1'b0);   // same bit again
    b = EndMark;
    b[3] = 8'h65;
    add_good(b, 1'b0);
    b = random_payload();
    add_packet(b, gen_ack, ~inet_checksum(b), 1'b0);  // stale bit and bad sum
    add_packet(random_payload(), ~gen_ack, 16'hFFFF, 1'b0);
    add_good(random_payload(), 1'b1);                 // hold until drained
    repeat (4) add_good(random_payload(), 1'b0);

    // --- random: mostly good traffic, some duplicates, bad sums, noise ---
    repeat (RandomPackets) begin
      b = random_payload();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_good(b, $urandom_range(0, 49) == 0);
      end else if (pick < 80) begin
        add_packet(b, gen_ack, inet_checksum(b), 1'b0);
      end else if (pick < 90) begin
        add_packet(b, ~gen_ack, inet_checksum(b) ^ 16'($urandom_range(1, 65535)),
                   1'b0);
      end else begin
        add_packet(b, 1'($urandom), ($urandom_range(0, 1) != 0) ? inet_checksum(b)
                                                                  : 16'($urandom),
                   1'b0);
      end
    end

    // end marker with arbitrary bit and sum, then traffic that must vanish
    add_packet(EndMark, 1'($urandom), 16'($urandom), 1'b0);
    repeat (3) add_good(random_payload(), 1'b0);
    add_packet(random_payload(), 1'($urandom), 16'($urandom), 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pkt_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (beats_due != beats_seen) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_stop_and_wait_receiver: clean");
    end else begin
      $display("tb_stop_and_wait_receiver: errors");
    end
    $finish;
  end

endmodule
